[hdl/pme_pkg.sv]
// Shared types, widths and codes for the point mass Euler integrator.
// No dependencies; imported by every module of the block.
package pme_pkg;

    localparam int WORD_BITS = 48;
    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;
    localparam int MODE_BITS = 2;
    localparam int FAULT_BITS = 2;

    // dividend is |force| with FRAC_BITS zeros appended
    localparam int DVD_BITS = WORD_BITS + FRAC_BITS;
    localparam int CNT_BITS = $clog2(DVD_BITS);

    localparam int IN_DATA_BITS  = ((4 * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_WORDS     = 7;
    localparam int OUT_DATA_BITS = ((OUT_WORDS * WORD_BITS + 7) / 8) * 8;

    localparam logic [WORD_BITS-1:0] MASS_ONE = WORD_BITS'(1) << FRAC_BITS;
    localparam logic [DT_BITS-1:0]   DT_RESET = DT_BITS'(655);

    localparam logic [MODE_BITS-1:0] MODE_FORCE   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_STEP    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_COMBINE = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_LOAD    = 2'd3;

    localparam logic [FAULT_BITS-1:0] FAULT_OK   = 2'd0;
    localparam logic [FAULT_BITS-1:0] FAULT_ZERO = 2'd1;
    localparam logic [FAULT_BITS-1:0] FAULT_SAT  = 2'd2;

    typedef struct packed {
        logic capture;
        logic decode;
        logic div_start;
        logic div_step;
        logic mul_acc;
        logic add_vel;
        logic mul_vel;
        logic add_pos;
        logic apply;
        logic load_out;
    } pme_cmd_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 mass_zero;
    } pme_status_t;

endpackage

[hdl/point_mass_euler_integrator_unit.sv]
// Top level of the point mass Euler integrator: stream ports, APB register.
// Depends on pme_pkg, pme_ctrl and pme_datapath.
//
//  channel   dir   handshake          payload
//  s_        in    s_tvalid/s_tready  s_tdata vectors and mass, s_tuser mode
//  m_        out   m_tvalid/m_tready  m_tdata state after item, m_tuser fault
//  apb       in    psel/penable       step_time at byte address 0
//
// Add force, combine and load pass through the decode, apply and finish phases.
// Step runs the 64-step restoring divider (one per axis, running in parallel)
// before its multiply and add phases; a step on zero mass skips the divider.
// aresetn is synchronous: body at rest at the origin, mass one, dt 655.
// The result sits in an output register; a stalled result holds the block
// in its final phase until m_tready, one request at a time.
module point_mass_euler_integrator_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // vec_x, vec_y, vec_z, mass_in
    input  logic [pme_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // mode
    input  logic [pme_pkg::MODE_BITS-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass_out
    output logic [pme_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    // fault
    output logic [pme_pkg::FAULT_BITS-1:0]       m_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import pme_pkg::*;

    localparam logic REG_STEP_TIME = 1'b0;

    pme_cmd_t    cmd;
    pme_status_t status;
    logic [DT_BITS-1:0] dt_reg;
    logic [2:0][WORD_BITS-1:0] in_vec;
    logic [OUT_WORDS*WORD_BITS-1:0] out_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STEP_TIME) ? 32'(dt_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg <= DT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_STEP_TIME) begin
            dt_reg <= pwdata[DT_BITS-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_vec[i] = s_tdata[i*WORD_BITS +: WORD_BITS];
        end
    end

    pme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pme_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (s_tuser),
        .in_vec    (in_vec),
        .in_mass   (s_tdata[3*WORD_BITS +: WORD_BITS]),
        .dt        (dt_reg),
        .out_data  (out_data),
        .out_fault (m_tuser)
    );

    assign m_tdata = OUT_DATA_BITS'(out_data);

    // one request in flight
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    a_fault_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == FAULT_OK || m_tuser == FAULT_ZERO || m_tuser == FAULT_SAT))
        else $error("bad fault code");

    // zero-mass fault must come with a zero mass in the result
    a_zero_mass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == FAULT_ZERO |->
            m_tdata[OUT_WORDS*WORD_BITS-1 -: WORD_BITS] == '0)
        else $error("zero-mass fault with non-zero mass");

endmodule

[hdl/pme_ctrl.sv]
// Sequencer for the integrator: handshakes, divide count, step phases.
// Depends on pme_pkg; drives pme_datapath through pme_cmd_t.
module pme_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  pme_pkg::pme_status_t status,
    output pme_pkg::pme_cmd_t    cmd
);
    import pme_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_APPLY  = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_MULA   = 4'd4;
    localparam logic [3:0] ST_ADDV   = 4'd5;
    localparam logic [3:0] ST_MULV   = 4'd6;
    localparam logic [3:0] ST_ADDP   = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                valid_reg, valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                if (status.mode != MODE_STEP) begin
                    state_next = ST_APPLY;
                end else if (status.mass_zero) begin
                    // no acceleration, position still moves
                    state_next = ST_MULV;
                end else begin
                    cmd.div_start = 1'b1;
                    cnt_next      = CNT_BITS'(DVD_BITS - 1);
                    state_next    = ST_DIV;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_MULA;
                end
            end
            ST_MULA: begin
                cmd.mul_acc = 1'b1;
                state_next  = ST_ADDV;
            end
            ST_ADDV: begin
                cmd.add_vel = 1'b1;
                state_next  = ST_MULV;
            end
            ST_MULV: begin
                cmd.mul_vel = 1'b1;
                state_next  = ST_ADDP;
            end
            ST_ADDP: begin
                cmd.add_pos = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (!valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[hdl/pme_datapath.sv]
// Datapath: body state, three restoring divider lanes, dt multipliers,
// saturating adders and the result register. Depends on pme_pkg.
module pme_datapath (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  pme_pkg::pme_cmd_t                          cmd,
    output pme_pkg::pme_status_t                       status,
    input  logic [pme_pkg::MODE_BITS-1:0]              in_mode,
    input  logic [2:0][pme_pkg::WORD_BITS-1:0]         in_vec,
    input  logic [pme_pkg::WORD_BITS-1:0]              in_mass,
    input  logic [pme_pkg::DT_BITS-1:0]                dt,
    output logic [pme_pkg::OUT_WORDS*pme_pkg::WORD_BITS-1:0] out_data,
    output logic [pme_pkg::FAULT_BITS-1:0]             out_fault
);
    import pme_pkg::*;

    localparam int W = WORD_BITS;
    localparam int PW = WORD_BITS + DT_BITS;

    // {saturated, clamped sum}
    function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            sat_add = {1'b1, s[W], {(W-1){!s[W]}}};
        end else begin
            sat_add = {1'b0, s[W-1:0]};
        end
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        mag = a[W-1] ? (~a + 1'b1) : a;
    endfunction

    // architectural state
    logic [W-1:0] pos_reg [3];
    logic [W-1:0] vel_reg [3];
    logic [W-1:0] frc_reg [3];
    logic [W-1:0] mass_reg;
    // item and working registers
    logic [MODE_BITS-1:0] mode_reg;
    logic [W-1:0]         vec_reg [3];
    logic [W-1:0]         min_reg;
    logic [W-1:0]         rem_reg [3];
    logic [DVD_BITS-1:0]  dq_reg [3];
    logic [W-1:0]         prod_reg [3];
    logic                 psgn_reg [3];
    logic                 sat_reg, zero_reg;
    logic [OUT_WORDS*W-1:0] out_data_reg;
    logic [FAULT_BITS-1:0]  out_fault_reg;

    // lane logic
    logic [W:0]      rem_sh [3];
    logic [W:0]      rem_sub [3];
    logic            div_ge [3];
    logic [W-1:0]    lim [3];
    logic            acc_over [3];
    logic [W-1:0]    mul_src [3];
    logic            mul_sgn [3];
    logic [PW-1:0]   mul_full [3];
    logic [W-1:0]    prod_s [3];
    logic [W:0]      vel_add [3];
    logic [W:0]      pos_add [3];
    logic [W:0]      frc_add [3];
    logic [W:0]      cmb_add [3];
    logic [W:0]      mass_sum;
    logic            sat_hit;

    assign status.mode      = mode_reg;
    assign status.mass_zero = (mass_reg == '0);
    assign mass_sum         = {1'b0, mass_reg} + {1'b0, min_reg};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rem_sh[i]  = {rem_reg[i], dq_reg[i][DVD_BITS-1]};
            rem_sub[i] = rem_sh[i] - {1'b0, mass_reg};
            div_ge[i]  = (rem_sh[i] >= {1'b0, mass_reg});
            // quotient limit: |SMIN| for negative force, SMAX otherwise
            lim[i]      = frc_reg[i][W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            acc_over[i] = (dq_reg[i] > {{FRAC_BITS{1'b0}}, lim[i]});
            if (cmd.mul_acc) begin
                mul_src[i] = acc_over[i] ? lim[i] : dq_reg[i][W-1:0];
                mul_sgn[i] = frc_reg[i][W-1];
            end else begin
                mul_src[i] = mag(vel_reg[i]);
                mul_sgn[i] = vel_reg[i][W-1];
            end
            mul_full[i] = {{DT_BITS{1'b0}}, mul_src[i]} * {{W{1'b0}}, dt};
            prod_s[i]   = psgn_reg[i] ? (~prod_reg[i] + 1'b1) : prod_reg[i];
            vel_add[i]  = sat_add(vel_reg[i], prod_s[i]);
            pos_add[i]  = sat_add(pos_reg[i], prod_s[i]);
            frc_add[i]  = sat_add(frc_reg[i], vec_reg[i]);
            cmb_add[i]  = sat_add(vel_reg[i], vec_reg[i]);
        end
    end

    always_comb begin
        sat_hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (cmd.mul_acc && acc_over[i]) sat_hit = 1'b1;
            if (cmd.add_vel && vel_add[i][W]) sat_hit = 1'b1;
            if (cmd.add_pos && pos_add[i][W]) sat_hit = 1'b1;
            if (cmd.apply && mode_reg == MODE_FORCE && frc_add[i][W]) sat_hit = 1'b1;
            if (cmd.apply && mode_reg == MODE_COMBINE && cmb_add[i][W]) sat_hit = 1'b1;
        end
        if (cmd.apply && mode_reg == MODE_COMBINE && mass_sum[W]) sat_hit = 1'b1;
    end

    // body state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                frc_reg[i] <= '0;
            end
            mass_reg <= MASS_ONE;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (cmd.add_vel) begin
                    vel_reg[i] <= vel_add[i][W-1:0];
                end
                if (cmd.add_pos) begin
                    pos_reg[i] <= pos_add[i][W-1:0];
                    frc_reg[i] <= '0;
                end
                if (cmd.apply) begin
                    case (mode_reg)
                        MODE_FORCE: begin
                            frc_reg[i] <= frc_add[i][W-1:0];
                        end
                        MODE_COMBINE: begin
                            vel_reg[i] <= cmb_add[i][W-1:0];
                        end
                        MODE_LOAD: begin
                            pos_reg[i] <= vec_reg[i];
                            vel_reg[i] <= '0;
                            frc_reg[i] <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (cmd.apply && mode_reg == MODE_COMBINE) begin
                mass_reg <= mass_sum[W] ? {W{1'b1}} : mass_sum[W-1:0];
            end
            if (cmd.apply && mode_reg == MODE_LOAD) begin
                mass_reg <= min_reg;
            end
        end
    end

    // item flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg  <= 1'b0;
            zero_reg <= 1'b0;
        end else if (cmd.capture) begin
            sat_reg  <= 1'b0;
            zero_reg <= 1'b0;
        end else begin
            if (sat_hit) sat_reg <= 1'b1;
            if (cmd.decode) zero_reg <= (mode_reg == MODE_STEP) && (mass_reg == '0);
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= in_mode;
            min_reg  <= in_mass;
            for (int i = 0; i < 3; i++) vec_reg[i] <= in_vec[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (cmd.div_start) begin
                rem_reg[i] <= '0;
                dq_reg[i]  <= {mag(frc_reg[i]), {FRAC_BITS{1'b0}}};
            end else if (cmd.div_step) begin
                // restoring step: dividend bits shift out, quotient bits in
                rem_reg[i] <= div_ge[i] ? rem_sub[i][W-1:0] : rem_sh[i][W-1:0];
                dq_reg[i]  <= {dq_reg[i][DVD_BITS-2:0], div_ge[i]};
            end
            if (cmd.mul_acc || cmd.mul_vel) begin
                prod_reg[i] <= mul_full[i][PW-1:DT_BITS];
                psgn_reg[i] <= mul_sgn[i];
            end
        end
        if (cmd.load_out) begin
            out_data_reg  <= {mass_reg, vel_reg[2], vel_reg[1], vel_reg[0],
                              pos_reg[2], pos_reg[1], pos_reg[0]};
            out_fault_reg <= zero_reg ? FAULT_ZERO : (sat_reg ? FAULT_SAT : FAULT_OK);
        end
    end

    assign out_data  = out_data_reg;
    assign out_fault = out_fault_reg;

endmodule
